// ----- design/ppurv_pkg.sv -----
// types, constants and address mapping shared by the register and vram port
// no dependencies
`default_nettype none

package ppurv_pkg;

  localparam int MEM_AW    = 14;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam logic [MEM_AW-1:0] NT_BASE  = 14'h2000;
  localparam logic [MEM_AW-1:0] PAL_BASE = 14'h2800;
  localparam logic [MEM_AW-1:0] SPR_BASE = 14'h3000;

  localparam logic [3:0]  NMI_DELAY     = 4'd15;
  localparam logic [7:0]  OAM_ATTR_MASK = 8'hE3;
  localparam logic [15:0] PAL_MIRROR    = 16'h1000;
  localparam logic [15:0] STEP_ROW      = 16'd32;
  localparam logic [15:0] STEP_ONE      = 16'd1;
  localparam logic [15:0] FINE_Y_ONE    = 16'h1000;
  localparam logic [15:0] COPYX_KEEP    = 16'hFBE0;
  localparam logic [15:0] COPYX_TAKE    = 16'h041F;
  localparam logic [15:0] COPYY_KEEP    = 16'h841F;
  localparam logic [15:0] COPYY_TAKE    = 16'h7BE0;
  localparam logic [4:0]  COARSE_LAST   = 5'd31;
  localparam logic [4:0]  ROW_LAST      = 5'd29;
  localparam logic [5:0]  PAL_PAGE      = 6'h3F;

  typedef enum logic [3:0] {
    OP_READ     = 4'd0,
    OP_WRITE    = 4'd1,
    OP_TICK     = 4'd2,
    OP_INCX     = 4'd3,
    OP_INCY     = 4'd4,
    OP_COPYX    = 4'd5,
    OP_COPYY    = 4'd6,
    OP_SETVBL   = 4'd7,
    OP_CLRVBL   = 4'd8,
    OP_ZEROHIT  = 4'd9,
    OP_OVERFLOW = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_t;

  typedef enum logic [2:0] {
    MIR_HORZ = 3'd0,
    MIR_VERT = 3'd1,
    MIR_FOUR = 3'd2,
    MIR_LOW  = 3'd3,
    MIR_HIGH = 3'd4
  } mirror_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_READ  = 2'd2
  } state_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] reg_sel;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_pulse;
    logic [15:0] vram_addr;
    logic [2:0]  fine_x;
    logic [7:0]  control_bits;
    logic [7:0]  mask_bits;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [MEM_AW-1:0] raddr_a;
    logic [MEM_AW-1:0] raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic clearing;
    logic mem_wait;
  } core_stat_t;

  // vram address to physical memory location
  function automatic logic [MEM_AW-1:0] vram_map(input logic [13:0] a,
                                                 input logic [2:0] mode);
    logic              tbl;
    logic [4:0]        p;
    logic [MEM_AW-1:0] m;
    tbl = 1'b0;
    p   = a[4:0];
    case (mirror_t'(mode))
      MIR_HORZ: tbl = a[11];
      MIR_VERT: tbl = a[10];
      MIR_FOUR: tbl = a[10];
      MIR_HIGH: tbl = 1'b1;
      default:  tbl = 1'b0;
    endcase
    if (p[4] && (p[1:0] == 2'b00)) begin
      p[4] = 1'b0;
    end
    if (!a[13]) begin
      m = {1'b0, a[12:0]};
    end else if (a[13:8] != PAL_PAGE) begin
      m = NT_BASE | {3'b000, tbl, a[9:0]};
    end else begin
      m = PAL_BASE | {9'b0, p};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/ppurv_if.sv -----
// valid/ready channel interfaces for items, results and the mirroring register
// no dependencies
`default_nettype none

interface ppurv_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [2:0] reg_sel;
  logic [7:0] write_data;
  modport source (output valid, opcode, reg_sel, write_data, input ready);
  modport sink (input valid, opcode, reg_sel, write_data, output ready);
endinterface

interface ppurv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        nmi_pulse;
  logic [15:0] vram_addr;
  logic [2:0]  fine_x;
  logic [7:0]  control_bits;
  logic [7:0]  mask_bits;
  modport source (output valid, read_data, nmi_pulse, vram_addr, fine_x, control_bits,
                  mask_bits, input ready);
  modport sink (input valid, read_data, nmi_pulse, vram_addr, fine_x, control_bits,
                mask_bits, output ready);
endinterface

interface ppurv_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] mirror_mode;
  modport source (output valid, mirror_mode, input ready);
  modport sink (input valid, mirror_mode, output ready);
endinterface

`default_nettype wire

// ----- design/ppu_register_vram_port.sv -----
// cpu-side register block with scroll address registers and video memory
// channels: in_chan takes one word per register access or renderer event,
//   out_chan returns one word per item (read byte, nmi pulse, address, fine x,
//   control and mask), cfg_chan writes the nametable mirroring mode
// result: a word enters the result queue when its item is taken; oam-data and
//   data reads push theirs from the read state, after the registered ram read
// throughput: one item per cycle while the queue has room; after an oam-data
//   or data read, the next waits out the read state; others go back to back
// reset: all registers clear, then a clearing pass zeroes the 16384-byte
//   video memory, one byte a cycle; in_chan.ready stays low during the pass,
//   cfg_chan is taken at any time
// stall: a two-word result queue holds finished words; in_chan.ready drops
//   when both entries wait on out_chan, and in the cycle after an
//   oam-data or data read is taken
// uses ppurv_pkg, ppurv_if, ppurv_ram, ppurv_out_q, ppurv_core
`default_nettype none

module ppu_register_vram_port (
  input  logic         clk,
  input  logic         rst_n,
  ppurv_in_if.sink     in_chan,
  ppurv_out_if.source  out_chan,
  ppurv_cfg_if.sink    cfg_chan
);
  import ppurv_pkg::*;

  in_word_t   in_word;
  out_word_t  res_word;
  out_word_t  head;
  mem_req_t   mem_req;
  core_stat_t stat;
  logic       res_push;
  logic       q_full;
  logic [7:0] mem_rd_a;
  logic [7:0] mem_rd_b;

  assign in_word = '{opcode: in_chan.opcode, reg_sel: in_chan.reg_sel,
                     write_data: in_chan.write_data};
  assign cfg_chan.ready = 1'b1;

  ppurv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_word    (in_word),
    .cfg_valid  (cfg_chan.valid),
    .cfg_mirror (cfg_chan.mirror_mode),
    .q_full     (q_full),
    .res_push   (res_push),
    .res_word   (res_word),
    .mem_req    (mem_req),
    .mem_rd_a   (mem_rd_a),
    .mem_rd_b   (mem_rd_b),
    .stat       (stat)
  );

  ppurv_ram u_ram (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (mem_rd_a),
    .rd_b (mem_rd_b)
  );

  ppurv_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_word (res_word),
    .pop       (out_chan.ready),
    .valid     (out_chan.valid),
    .head      (head),
    .full      (q_full)
  );

  assign out_chan.read_data    = head.read_data;
  assign out_chan.nmi_pulse    = head.nmi_pulse;
  assign out_chan.vram_addr    = head.vram_addr;
  assign out_chan.fine_x       = head.fine_x;
  assign out_chan.control_bits = head.control_bits;
  assign out_chan.mask_bits    = head.mask_bits;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !stat.clearing)
    else $error("item taken during memory clearing pass");

  a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mem_wait |-> res_push)
    else $error("memory read did not deliver its word");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mem_wait |=> !stat.mem_wait)
    else $error("memory read wait lasted more than one cycle");

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!q_full || out_chan.ready))
    else $error("result pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ----- design/ppurv_ram.sv -----
// unified video memory: pattern, nametable, palette and sprite bytes
// one write port, two registered read ports; uses ppurv_pkg
`default_nettype none

module ppurv_ram (
  input  logic                clk,
  input  ppurv_pkg::mem_req_t req,
  output logic [7:0]          rd_a,
  output logic [7:0]          rd_b
);
  import ppurv_pkg::*;

  logic [7:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

`default_nettype wire

// ----- design/ppurv_out_q.sv -----
// two-word result queue between the register core and the result channel
// uses ppurv_pkg
`default_nettype none

module ppurv_out_q (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ppurv_pkg::out_word_t push_word,
  input  logic                 pop,
  output logic                 valid,
  output ppurv_pkg::out_word_t head,
  output logic                 full
);
  import ppurv_pkg::*;

  out_word_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign valid  = (cnt_r != 2'd0);
  assign full   = (cnt_r == 2'd2);
  assign head   = slot_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

// ----- design/ppurv_core.sv -----
// register file, scroll address logic, nmi delay and memory sequencing
// uses ppurv_pkg; drives ppurv_ram and ppurv_out_q
`default_nettype none

module ppurv_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ppurv_pkg::in_word_t   in_word,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_mirror,
  input  logic                  q_full,
  output logic                  res_push,
  output ppurv_pkg::out_word_t  res_word,
  output ppurv_pkg::mem_req_t   mem_req,
  input  logic [7:0]            mem_rd_a,
  input  logic [7:0]            mem_rd_b,
  output ppurv_pkg::core_stat_t stat
);
  import ppurv_pkg::*;

  state_t            state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [2:0]        mirror_r;
  logic [15:0]       temp_r, temp_nxt;
  logic [15:0]       cur_r, cur_nxt;
  logic [2:0]        fine_r, fine_nxt;
  logic              toggle_r, toggle_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [7:0]        spr_addr_r, spr_addr_nxt;
  logic [7:0]        rbuf_r, rbuf_nxt;
  logic [7:0]        last_r, last_nxt;
  logic              vbl_r, vbl_nxt;
  logic              hit_r, hit_nxt;
  logic              ovf_r, ovf_nxt;
  logic              nmi_lvl_r, nmi_lvl_nxt;
  logic [3:0]        nmi_cnt_r, nmi_cnt_nxt;
  logic              pend_oam_r, pend_oam_nxt;
  logic              pend_attr_r, pend_attr_nxt;
  logic              pend_pal_r, pend_pal_nxt;

  logic              accept;
  logic              is_mem_rd;
  logic [15:0]       step;
  logic [15:0]       cur_less;
  logic [MEM_AW-1:0] cur_loc;
  logic [4:0]        row;
  logic              lvl;
  logic [7:0]        rd;
  logic              pulse;

  assign in_ready  = (state_r == ST_IDLE) && !q_full;
  assign accept    = in_valid && in_ready;
  assign is_mem_rd = (op_t'(in_word.opcode) == OP_READ) &&
                     ((reg_t'(in_word.reg_sel) == REG_OAM_DATA) ||
                      (reg_t'(in_word.reg_sel) == REG_DATA));
  assign step      = ctrl_r[2] ? STEP_ROW : STEP_ONE;
  assign cur_less  = cur_r - PAL_MIRROR;
  assign cur_loc   = vram_map(cur_r[13:0], mirror_r);
  assign stat      = '{clearing: (state_r == ST_CLEAR), mem_wait: (state_r == ST_READ)};

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && is_mem_rd) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory requests
  always_comb begin
    mem_req.we      = 1'b0;
    mem_req.waddr   = cur_loc;
    mem_req.wdata   = in_word.write_data;
    mem_req.raddr_a = (reg_t'(in_word.reg_sel) == REG_OAM_DATA) ?
                      (SPR_BASE | {6'b0, spr_addr_r}) : cur_loc;
    mem_req.raddr_b = vram_map(cur_less[13:0], mirror_r);
    if (state_r == ST_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = clr_cnt_r;
      mem_req.wdata = 8'h00;
    end else if (accept && (op_t'(in_word.opcode) == OP_WRITE)) begin
      if (reg_t'(in_word.reg_sel) == REG_OAM_DATA) begin
        mem_req.we    = 1'b1;
        mem_req.waddr = SPR_BASE | {6'b0, spr_addr_r};
      end else if (reg_t'(in_word.reg_sel) == REG_DATA) begin
        mem_req.we = 1'b1;
      end
    end
  end

  // register updates and results
  always_comb begin
    temp_nxt      = temp_r;
    cur_nxt       = cur_r;
    fine_nxt      = fine_r;
    toggle_nxt    = toggle_r;
    ctrl_nxt      = ctrl_r;
    mask_nxt      = mask_r;
    spr_addr_nxt  = spr_addr_r;
    rbuf_nxt      = rbuf_r;
    last_nxt      = last_r;
    vbl_nxt       = vbl_r;
    hit_nxt       = hit_r;
    ovf_nxt       = ovf_r;
    nmi_lvl_nxt   = nmi_lvl_r;
    nmi_cnt_nxt   = nmi_cnt_r;
    pend_oam_nxt  = pend_oam_r;
    pend_attr_nxt = pend_attr_r;
    pend_pal_nxt  = pend_pal_r;
    row           = cur_r[9:5];
    lvl           = 1'b0;
    rd            = 8'h00;
    pulse         = 1'b0;
    res_push      = 1'b0;

    if (accept) begin
      case (op_t'(in_word.opcode))
        OP_READ: begin
          case (reg_t'(in_word.reg_sel))
            REG_STATUS: begin
              rd         = {vbl_r, hit_r, ovf_r, last_r[4:0]};
              vbl_nxt    = 1'b0;
              toggle_nxt = 1'b0;
            end
            REG_OAM_DATA: begin
              pend_oam_nxt  = 1'b1;
              pend_attr_nxt = (spr_addr_r[1:0] == 2'b10);
            end
            REG_DATA: begin
              pend_oam_nxt = 1'b0;
              pend_pal_nxt = (cur_r[13:8] == PAL_PAGE);
              cur_nxt      = cur_r + step;
            end
            default: rd = 8'h00;
          endcase
        end
        OP_WRITE: begin
          last_nxt = in_word.write_data;
          case (reg_t'(in_word.reg_sel))
            REG_CTRL: begin
              ctrl_nxt       = in_word.write_data;
              temp_nxt[11:10] = in_word.write_data[1:0];
            end
            REG_MASK:     mask_nxt = in_word.write_data;
            REG_OAM_ADDR: spr_addr_nxt = in_word.write_data;
            REG_OAM_DATA: spr_addr_nxt = spr_addr_r + 8'd1;
            REG_SCROLL: begin
              if (!toggle_r) begin
                temp_nxt[4:0] = in_word.write_data[7:3];
                fine_nxt      = in_word.write_data[2:0];
                toggle_nxt    = 1'b1;
              end else begin
                temp_nxt[14:12] = in_word.write_data[2:0];
                temp_nxt[9:5]   = in_word.write_data[7:3];
                toggle_nxt      = 1'b0;
              end
            end
            REG_ADDR: begin
              if (!toggle_r) begin
                temp_nxt[14]   = 1'b0;
                temp_nxt[13:8] = in_word.write_data[5:0];
                toggle_nxt     = 1'b1;
              end else begin
                temp_nxt[7:0] = in_word.write_data;
                cur_nxt       = {temp_r[15:8], in_word.write_data};
                toggle_nxt    = 1'b0;
              end
            end
            REG_DATA: cur_nxt = cur_r + step;
            default:  last_nxt = in_word.write_data;
          endcase
        end
        OP_TICK: begin
          if (nmi_cnt_r != 4'd0) begin
            nmi_cnt_nxt = nmi_cnt_r - 4'd1;
            pulse       = (nmi_cnt_r == 4'd1) && ctrl_r[7] && vbl_r;
          end
        end
        OP_INCX: begin
          if (cur_r[4:0] == COARSE_LAST) begin
            cur_nxt[4:0] = 5'd0;
            cur_nxt[10]  = ~cur_r[10];
          end else begin
            cur_nxt = cur_r + STEP_ONE;
          end
        end
        OP_INCY: begin
          if (cur_r[14:12] != 3'b111) begin
            cur_nxt = cur_r + FINE_Y_ONE;
          end else begin
            cur_nxt[14:12] = 3'b000;
            if (cur_r[9:5] == ROW_LAST) begin
              row         = 5'd0;
              cur_nxt[11] = ~cur_r[11];
            end else if (cur_r[9:5] == COARSE_LAST) begin
              row = 5'd0;
            end else begin
              row = cur_r[9:5] + 5'd1;
            end
            cur_nxt[9:5] = row;
          end
        end
        OP_COPYX:    cur_nxt = (cur_r & COPYX_KEEP) | (temp_r & COPYX_TAKE);
        OP_COPYY:    cur_nxt = (cur_r & COPYY_KEEP) | (temp_r & COPYY_TAKE);
        OP_SETVBL:   vbl_nxt = 1'b1;
        OP_CLRVBL: begin
          vbl_nxt = 1'b0;
          hit_nxt = 1'b0;
          ovf_nxt = 1'b0;
        end
        OP_ZEROHIT:  hit_nxt = 1'b1;
        OP_OVERFLOW: ovf_nxt = 1'b1;
        default:     rd = 8'h00;
      endcase

      // nmi level edge
      lvl = ctrl_nxt[7] & vbl_nxt;
      if (lvl && !nmi_lvl_r) begin
        nmi_cnt_nxt = NMI_DELAY;
      end
      nmi_lvl_nxt = lvl;
      res_push    = !is_mem_rd;
    end else if (state_r == ST_READ) begin
      res_push = 1'b1;
      if (pend_oam_r) begin
        rd = mem_rd_a & (pend_attr_r ? OAM_ATTR_MASK : 8'hFF);
      end else if (pend_pal_r) begin
        rd       = mem_rd_a;
        rbuf_nxt = mem_rd_b;
      end else begin
        rd       = rbuf_r;
        rbuf_nxt = mem_rd_a;
      end
    end

    res_word = '{read_data: rd, nmi_pulse: pulse, vram_addr: cur_nxt, fine_x: fine_nxt,
                 control_bits: ctrl_nxt, mask_bits: mask_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      mirror_r    <= 3'd0;
      temp_r      <= 16'd0;
      cur_r       <= 16'd0;
      fine_r      <= 3'd0;
      toggle_r    <= 1'b0;
      ctrl_r      <= 8'd0;
      mask_r      <= 8'd0;
      spr_addr_r  <= 8'd0;
      rbuf_r      <= 8'd0;
      last_r      <= 8'd0;
      vbl_r       <= 1'b0;
      hit_r       <= 1'b0;
      ovf_r       <= 1'b0;
      nmi_lvl_r   <= 1'b0;
      nmi_cnt_r   <= 4'd0;
      pend_oam_r  <= 1'b0;
      pend_attr_r <= 1'b0;
      pend_pal_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      if (cfg_valid) begin
        mirror_r <= cfg_mirror;
      end
      temp_r      <= temp_nxt;
      cur_r       <= cur_nxt;
      fine_r      <= fine_nxt;
      toggle_r    <= toggle_nxt;
      ctrl_r      <= ctrl_nxt;
      mask_r      <= mask_nxt;
      spr_addr_r  <= spr_addr_nxt;
      rbuf_r      <= rbuf_nxt;
      last_r      <= last_nxt;
      vbl_r       <= vbl_nxt;
      hit_r       <= hit_nxt;
      ovf_r       <= ovf_nxt;
      nmi_lvl_r   <= nmi_lvl_nxt;
      nmi_cnt_r   <= nmi_cnt_nxt;
      pend_oam_r  <= pend_oam_nxt;
      pend_attr_r <= pend_attr_nxt;
      pend_pal_r  <= pend_pal_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- tb/ppurv_checker.sv -----
// checker for the register and vram port: predicts one result word per accepted
// item from its own copy of the registers and memories, and compares it on out
// depends on ppurv_pkg and the channel interfaces in ppurv_if
`timescale 1ns / 1ps

module ppurv_checker (
  input  logic  clk,
  input  logic  rst_n,
  ppurv_in_if   in_mon,
  ppurv_out_if  out_mon,
  ppurv_cfg_if  cfg_mon,
  output int    errors,
  output int    pending,
  output int    words_checked,
  output int    nmi_seen
);
  import ppurv_pkg::*;

  logic [2:0]  mirror;
  logic [15:0] t_addr;
  logic [15:0] v_addr;
  logic [2:0]  fine_x;
  logic        toggle;
  logic [7:0]  ctrl;
  logic [7:0]  mask;
  logic [7:0]  spr_ptr;
  logic [7:0]  read_buf;
  logic [7:0]  last_byte;
  logic        vblank;
  logic        hit;
  logic        ovf;
  logic        nmi_level;
  logic [3:0]  nmi_count;
  logic [7:0]  chr_ram [8192];
  logic [7:0]  nt_ram [2048];
  logic [7:0]  pal_ram [32];
  logic [7:0]  oam_ram [256];
  out_word_t   due_words [$];

  function automatic void clear_model();
    mirror    = MIR_HORZ;
    t_addr    = '0;
    v_addr    = '0;
    fine_x    = '0;
    toggle    = 1'b0;
    ctrl      = '0;
    mask      = '0;
    spr_ptr   = '0;
    read_buf  = '0;
    last_byte = '0;
    vblank    = 1'b0;
    hit       = 1'b0;
    ovf       = 1'b0;
    nmi_level = 1'b0;
    nmi_count = '0;
    foreach (chr_ram[i]) chr_ram[i] = '0;
    foreach (nt_ram[i]) nt_ram[i] = '0;
    foreach (pal_ram[i]) pal_ram[i] = '0;
    foreach (oam_ram[i]) oam_ram[i] = '0;
  endfunction

  // 2 KB of table ram: tables 2 and 3 fold onto 0 and 1 in four-screen mode
  function automatic logic [10:0] nt_slot(input logic [15:0] a);
    logic [1:0] quad;
    logic       tbl;
    quad = a[11:10];
    case (mirror)
      MIR_HORZ: tbl = quad[1];
      MIR_VERT: tbl = quad[0];
      MIR_FOUR: tbl = quad[0];
      MIR_HIGH: tbl = 1'b1;
      default:  tbl = 1'b0;
    endcase
    return {tbl, a[9:0]};
  endfunction

  function automatic logic [4:0] pal_slot(input logic [15:0] a);
    logic [4:0] p;
    p = a[4:0];
    if (p >= 5'd16 && p[1:0] == 2'b00) begin
      p = p - 5'd16;
    end
    return p;
  endfunction

  function automatic logic [7:0] vram_fetch(input logic [15:0] a);
    logic [13:0] m;
    m = a[13:0];
    if (m < 14'h2000) begin
      return chr_ram[m[12:0]];
    end else if (m < 14'h3F00) begin
      return nt_ram[nt_slot(a)];
    end
    return pal_ram[pal_slot(a)];
  endfunction

  function automatic void vram_store(input logic [15:0] a, input logic [7:0] d);
    logic [13:0] m;
    m = a[13:0];
    if (m < 14'h2000) begin
      chr_ram[m[12:0]] = d;
    end else if (m < 14'h3F00) begin
      nt_ram[nt_slot(a)] = d;
    end else begin
      pal_ram[pal_slot(a)] = d;
    end
  endfunction

  // rising edge of enable-and-vblank loads the delay
  function automatic void nmi_follow();
    logic lvl;
    lvl = ctrl[7] & vblank;
    if (lvl && !nmi_level) begin
      nmi_count = NMI_DELAY;
    end
    nmi_level = lvl;
  endfunction

  function automatic void step_addr();
    v_addr = v_addr + (ctrl[2] ? 16'd32 : 16'd1);
  endfunction

  function automatic out_word_t port_response(input logic [3:0] op, input logic [2:0] sel,
                                              input logic [7:0] d);
    out_word_t  w;
    logic [7:0] rd;
    logic       pulse;
    logic [4:0] row;
    rd = '0;
    pulse = 1'b0;
    case (op)
      OP_READ: begin
        case (sel)
          REG_STATUS: begin
            rd = {vblank, hit, ovf, last_byte[4:0]};
            vblank = 1'b0;
            nmi_follow();
            toggle = 1'b0;
          end
          REG_OAM_DATA: begin
            rd = oam_ram[spr_ptr];
            if (spr_ptr[1:0] == 2'd2) begin
              rd = rd & OAM_ATTR_MASK;
            end
          end
          REG_DATA: begin
            rd = vram_fetch(v_addr);
            if (v_addr[13:0] < 14'h3F00) begin
              {rd, read_buf} = {read_buf, rd};
            end else begin
              read_buf = vram_fetch(v_addr - PAL_MIRROR);
            end
            step_addr();
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        last_byte = d;
        case (sel)
          REG_CTRL: begin
            ctrl = d;
            nmi_follow();
            t_addr[11:10] = d[1:0];
          end
          REG_MASK: mask = d;
          REG_OAM_ADDR: spr_ptr = d;
          REG_OAM_DATA: begin
            oam_ram[spr_ptr] = d;
            spr_ptr = spr_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle) begin
              t_addr[4:0] = d[7:3];
              fine_x = d[2:0];
            end else begin
              t_addr[14:12] = d[2:0];
              t_addr[9:5] = d[7:3];
            end
            toggle = ~toggle;
          end
          REG_ADDR: begin
            if (!toggle) begin
              t_addr[14:8] = {1'b0, d[5:0]};
            end else begin
              t_addr[7:0] = d;
              v_addr = t_addr;
            end
            toggle = ~toggle;
          end
          REG_DATA: begin
            vram_store(v_addr, d);
            step_addr();
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (nmi_count != 4'd0) begin
          nmi_count = nmi_count - 4'd1;
          if (nmi_count == 4'd0 && ctrl[7] && vblank) begin
            pulse = 1'b1;
          end
        end
      end
      OP_INCX: begin
        if (v_addr[4:0] == COARSE_LAST) begin
          v_addr[4:0] = 5'd0;
          v_addr[10] = ~v_addr[10];
        end else begin
          v_addr = v_addr + 16'd1;
        end
      end
      OP_INCY: begin
        if (v_addr[14:12] != 3'd7) begin
          v_addr = v_addr + FINE_Y_ONE;
        end else begin
          v_addr[14:12] = 3'd0;
          row = v_addr[9:5];
          if (row == ROW_LAST) begin
            row = 5'd0;
            v_addr[11] = ~v_addr[11];
          end else if (row == 5'd31) begin
            row = 5'd0;
          end else begin
            row = row + 5'd1;
          end
          v_addr[9:5] = row;
        end
      end
      OP_COPYX: v_addr = (v_addr & COPYX_KEEP) | (t_addr & COPYX_TAKE);
      OP_COPYY: v_addr = (v_addr & COPYY_KEEP) | (t_addr & COPYY_TAKE);
      OP_SETVBL: begin
        vblank = 1'b1;
        nmi_follow();
      end
      OP_CLRVBL: begin
        vblank = 1'b0;
        hit = 1'b0;
        ovf = 1'b0;
        nmi_follow();
      end
      OP_ZEROHIT: hit = 1'b1;
      OP_OVERFLOW: ovf = 1'b1;
      default: ;
    endcase
    w.read_data = rd;
    w.nmi_pulse = pulse;
    w.vram_addr = v_addr;
    w.fine_x = fine_x;
    w.control_bits = ctrl;
    w.mask_bits = mask;
    return w;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      clear_model();
      due_words.delete();
      errors = 0;
      words_checked = 0;
      nmi_seen = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        mirror = cfg_mon.mirror_mode;
      end
      if (out_mon.valid && out_mon.ready) begin
        words_checked++;
        if (out_mon.nmi_pulse) begin
          nmi_seen++;
        end
        if (due_words.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result word at %0t ns", $time);
          end
        end else begin
          want = due_words.pop_front();
          if (want.read_data !== out_mon.read_data || want.nmi_pulse !== out_mon.nmi_pulse ||
              want.vram_addr !== out_mon.vram_addr || want.fine_x !== out_mon.fine_x ||
              want.control_bits !== out_mon.control_bits ||
              want.mask_bits !== out_mon.mask_bits) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t ns: expected rd=%h nmi=%b addr=%h fx=%0d ctrl=%h mask=%h",
                       $time, want.read_data, want.nmi_pulse, want.vram_addr, want.fine_x,
                       want.control_bits, want.mask_bits);
              $display("                      actual rd=%h nmi=%b addr=%h fx=%0d ctrl=%h mask=%h",
                       out_mon.read_data, out_mon.nmi_pulse, out_mon.vram_addr,
                       out_mon.fine_x, out_mon.control_bits, out_mon.mask_bits);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        due_words.push_back(port_response(in_mon.opcode, in_mon.reg_sel, in_mon.write_data));
      end
    end
    pending = due_words.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// top of the register and vram port testbench: clock, reset, directed and
// random item stimulus, mirroring writes, random stalls, watchdog and verdict
// depends on ppurv_pkg, ppurv_if, ppu_register_vram_port and ppurv_checker
`timescale 1ns / 1ps

module tb_top;
  import ppurv_pkg::*;

  localparam int         QUIET_LIMIT   = 50000;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         PHASE_ITEMS   = 88;
  localparam logic [2:0] MIR_SPARE     = 3'd7;
  localparam logic [3:0] OP_SPARE      = 4'd15;

  logic clk = 1'b0;
  logic rst_n;
  int   errors;
  int   pending;
  int   words_checked;
  int   nmi_seen;
  int   items_sent;
  int   settings_used;
  bit   gappy;
  bit   hold_req;

  ppurv_in_if  in_chan ();
  ppurv_out_if out_chan ();
  ppurv_cfg_if cfg_chan ();

  always #1 clk = ~clk;

  ppu_register_vram_port dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ppurv_checker port_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .errors        (errors),
    .pending       (pending),
    .words_checked (words_checked),
    .nmi_seen      (nmi_seen)
  );

  task automatic send_word(input logic [3:0] op, input logic [2:0] sel, input logic [7:0] d);
    int gap;
    gap = 0;
    if (gappy) begin
      gap = $urandom_range(0, 99);
      if (gap < 65) begin
        gap = 0;
      end else if (gap < 93) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(6, 30);
      end
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= op;
    in_chan.reg_sel    <= sel;
    in_chan.write_data <= d;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic cpu_write(input logic [2:0] sel, input logic [7:0] d);
    send_word(OP_WRITE, sel, d);
  endtask

  task automatic cpu_read(input logic [2:0] sel);
    send_word(OP_READ, sel, 8'($urandom));
  endtask

  task automatic renderer_event(input logic [3:0] op);
    send_word(op, 3'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mirror(input logic [2:0] m);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.mirror_mode <= m;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    settings_used++;
  endtask

  // high address byte aimed at pattern, table or palette space
  function automatic logic [7:0] pick_page();
    logic [5:0] pg;
    case ($urandom_range(0, 3))
      0:       pg = 6'($urandom_range(0, 6'h1F));
      3:       pg = PAL_PAGE;
      default: pg = 6'($urandom_range(6'h20, 6'h3E));
    endcase
    return {2'($urandom), pg};
  endfunction

  task automatic run_sequence();
    int         kind;
    int         n;
    int         style;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // address load then a burst of data accesses
      if ($urandom_range(0, 4) == 0) cpu_write(REG_CTRL, 8'($urandom));
      if ($urandom_range(0, 2) == 0) cpu_read(REG_STATUS);
      cpu_write(REG_ADDR, pick_page());
      cpu_write(REG_ADDR, 8'($urandom));
      n = $urandom_range(1, 6);
      style = $urandom_range(0, 2);
      repeat (n) begin
        if (style == 1 || (style == 2 && $urandom_range(0, 1) == 1)) begin
          cpu_write(REG_DATA, 8'($urandom));
        end else begin
          cpu_read(REG_DATA);
        end
      end
    end else if (kind < 45) begin
      // one scanline of renderer address updates
      renderer_event(OP_COPYX);
      n = $urandom_range(1, 10);
      repeat (n) renderer_event(OP_INCX);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : 1;
      repeat (n) renderer_event(OP_INCY);
      if ($urandom_range(0, 2) == 0) renderer_event(OP_COPYY);
      if ($urandom_range(0, 3) == 0) renderer_event(OP_ZEROHIT);
      if ($urandom_range(0, 3) == 0) renderer_event(OP_OVERFLOW);
    end else if (kind < 60) begin
      // vblank with nmi countdown
      b = 8'($urandom);
      if ($urandom_range(0, 9) < 7) b[7] = 1'b1;
      cpu_write(REG_CTRL, b);
      renderer_event(OP_SETVBL);
      if ($urandom_range(0, 3) == 0) begin
        cpu_write(REG_CTRL, b & 8'h7F);
        cpu_write(REG_CTRL, b | 8'h80);
      end
      n = $urandom_range(12, 18);
      repeat (n) renderer_event(OP_TICK);
      if ($urandom_range(0, 1) == 1) cpu_read(REG_STATUS);
      renderer_event(OP_CLRVBL);
    end else if (kind < 70) begin
      // scroll pair then copies into the current address
      cpu_read(REG_STATUS);
      cpu_write(REG_SCROLL, 8'($urandom));
      cpu_write(REG_SCROLL, 8'($urandom));
      if ($urandom_range(0, 1) == 1) renderer_event(OP_COPYY);
      renderer_event(OP_COPYX);
    end else if (kind < 80) begin
      b = 8'($urandom);
      cpu_write(REG_OAM_ADDR, b);
      n = $urandom_range(1, 4);
      repeat (n) cpu_write(REG_OAM_DATA, 8'($urandom));
      cpu_write(REG_OAM_ADDR, b);
      cpu_read(REG_OAM_DATA);
      cpu_write(REG_OAM_ADDR, b + 8'($urandom_range(0, 3)));
      cpu_read(REG_OAM_DATA);
    end else if (kind < 92) begin
      send_word(4'($urandom_range(0, 1)), 3'($urandom), 8'($urandom));
    end else begin
      send_word(4'($urandom), 3'($urandom), 8'($urandom));
    end
  endtask

  initial begin : receiver
    int r;
    int stall_left;
    int steady_left;
    stall_left = 0;
    steady_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        out_chan.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          steady_left = $urandom_range(40, 160);
        end else if (r < 22) begin
          stall_left = $urandom_range(1, 3);
        end else if (r < 25) begin
          stall_left = $urandom_range(8, 40);
        end
        out_chan.ready <= (stall_left == 0);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no word moved for %0d cycles", QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int         p;
    int         goal;
    logic [2:0] modes [6];
    modes = '{MIR_HORZ, MIR_VERT, MIR_FOUR, MIR_LOW, MIR_HIGH, MIR_SPARE};
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = '0;
    in_chan.reg_sel = '0;
    in_chan.write_data = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.mirror_mode = '0;
    gappy = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    settings_used = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mirror(MIR_VERT);

    // palette mirror entry, then a direct palette read
    cpu_write(REG_ADDR, 8'hFF);
    cpu_write(REG_ADDR, 8'h10);
    cpu_write(REG_DATA, 8'hFF);
    cpu_write(REG_ADDR, 8'h3F);
    cpu_write(REG_ADDR, 8'h00);
    cpu_read(REG_DATA);
    // buffered table read
    cpu_write(REG_ADDR, 8'h24);
    cpu_write(REG_ADDR, 8'h00);
    cpu_write(REG_DATA, 8'hA5);
    cpu_write(REG_ADDR, 8'h24);
    cpu_write(REG_ADDR, 8'h00);
    cpu_read(REG_DATA);
    cpu_read(REG_DATA);
    // oam attribute mask and address wrap
    cpu_write(REG_OAM_ADDR, 8'hFE);
    cpu_write(REG_OAM_DATA, 8'hFF);
    cpu_write(REG_OAM_DATA, 8'h00);
    cpu_write(REG_OAM_ADDR, 8'hFE);
    cpu_read(REG_OAM_DATA);
    cpu_write(REG_SCROLL, 8'hFF);
    cpu_write(REG_SCROLL, 8'hFF);
    cpu_write(REG_CTRL, 8'h84);
    renderer_event(OP_SETVBL);
    renderer_event(OP_ZEROHIT);
    renderer_event(OP_OVERFLOW);
    cpu_read(REG_STATUS);
    cpu_read(REG_MASK);
    renderer_event(OP_CLRVBL);
    renderer_event(OP_INCX);
    renderer_event(OP_INCY);
    renderer_event(OP_COPYX);
    renderer_event(OP_COPYY);
    renderer_event(OP_TICK);
    renderer_event(OP_SPARE);

    for (p = 0; p < 6; p++) begin
      drain();
      set_mirror(modes[p]);
      if (p == 1) hold_req = 1'b1;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        gappy = (p != 1) && ($urandom_range(0, 3) != 0);
        run_sequence();
      end
    end
    drain();

    $display("ran %0d items under %0d mirroring settings with random stalls on both sides",
             items_sent, settings_used);
    $display("compared %0d result words, %0d nmi pulses, %0d errors",
             words_checked, nmi_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
